### sv/bmmd_pkg.sv
// Package for the banked memory map decoder.
// Holds operation, source and select codes, region sizes, default bases and
// the decode struct. No dependencies.
package bmmd_pkg;

    // Default region bases
    localparam logic [15:0] BMMD_KERNAL_BASE   = 16'hE000;
    localparam logic [15:0] BMMD_BASIC_BASE    = 16'hA000;
    localparam logic [15:0] BMMD_CHAR_BASE     = 16'hD000;
    localparam logic [15:0] BMMD_DEV1_BASE     = 16'hDC00;
    localparam logic [15:0] BMMD_DEV2_BASE     = 16'hDD00;
    localparam logic [15:0] BMMD_BANK_REG_ADDR = 16'h0001;

    // Region sizes in bytes
    localparam int unsigned KERNAL_SIZE = 8192;
    localparam int unsigned BASIC_SIZE  = 8192;
    localparam int unsigned CHAR_SIZE   = 4096;
    localparam int unsigned DEV_SIZE    = 256;

    // Combined ROM store: kernal, then basic, then char
    localparam int unsigned ROM_DEPTH = KERNAL_SIZE + BASIC_SIZE + CHAR_SIZE;
    localparam int unsigned ROM_AW    = $clog2(ROM_DEPTH);
    localparam logic [ROM_AW-1:0] ROM_KERNAL_OFS = ROM_AW'(0);
    localparam logic [ROM_AW-1:0] ROM_BASIC_OFS  = ROM_AW'(KERNAL_SIZE);
    localparam logic [ROM_AW-1:0] ROM_CHAR_OFS   = ROM_AW'(KERNAL_SIZE + BASIC_SIZE);

    // Map flag bit positions
    localparam int unsigned FLAG_BASIC  = 0;
    localparam int unsigned FLAG_KERNAL = 1;
    localparam int unsigned FLAG_IO     = 2;
    localparam int unsigned FLAG_CHAR   = 3;

    // Bank register bit masks
    localparam logic [2:0] BANK_ROM_MASK = 3'h3;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LOAD  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        SRC_RAM    = 3'd0,
        SRC_KERNAL = 3'd1,
        SRC_BASIC  = 3'd2,
        SRC_CHAR   = 3'd3,
        SRC_DEV1   = 3'd4,
        SRC_DEV2   = 3'd5,
        SRC_DROP   = 3'd6
    } t_src;

    typedef enum logic [1:0] {
        DSEL_NONE = 2'd0,
        DSEL_DEV1 = 2'd1,
        DSEL_DEV2 = 2'd2
    } t_dsel;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Region decode of one address under the current map flags
    typedef struct packed {
        logic              in_k;
        logic              in_c;
        logic              in_b;
        logic              hit_k;
        logic              hit_c;
        logic              hit_b;
        logic              hit_d1;
        logic              hit_d2;
        logic [ROM_AW-1:0] rom_rd_idx;   // image entry a read would use
        logic [ROM_AW-1:0] rom_ld_idx;   // image entry a load would write
    } t_decode;

    // Map flags from the low three bits of a bank register write
    function automatic logic [3:0] bank_flags(input logic [2:0] v);
        logic [3:0] f;
        f = 4'h0;
        if ((v & BANK_ROM_MASK) != 3'h0) begin
            f[FLAG_BASIC]  = v[0];
            f[FLAG_KERNAL] = v[1];
            f[FLAG_IO]     = v[2];
            f[FLAG_CHAR]   = ~v[2];
        end
        return f;
    endfunction

endpackage

### sv/banked_memory_map_decoder_core.sv
// Top level of the banked memory map decoder: RAM and ROM stores, map flags,
// control sequencer and output register. Depends on bmmd_pkg, bmmd_decode.
// An item accepted in idle moves to execute, where it is loaded into the output
//   register; it stays in execute while the output register is still full.
// A new item is accepted only after the last one leaves execute (accept/read, then
//   execute/write), since the RAM and ROM stores are read synchronously.
// Reset (i_rst_n low, synchronous): map flags clear, output empties, then a
//   clearing pass zeroes all 65536 main RAM bytes with s_axis_tready low.
module banked_memory_map_decoder_core
    import bmmd_pkg::*;
#(
    parameter logic [15:0] KERNAL_BASE   = BMMD_KERNAL_BASE,
    parameter logic [15:0] BASIC_BASE    = BMMD_BASIC_BASE,
    parameter logic [15:0] CHAR_BASE     = BMMD_CHAR_BASE,
    parameter logic [15:0] DEV1_BASE     = BMMD_DEV1_BASE,
    parameter logic [15:0] DEV2_BASE     = BMMD_DEV2_BASE,
    parameter logic [15:0] BANK_REG_ADDR = BMMD_BANK_REG_ADDR
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // address[15:0], write_data[23:16],
                                        // device_read_data[31:24]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // read_data[7:0], device_select[9:8],
                                        // device_write[10], device_address[26:11],
                                        // device_write_data[34:27],
                                        // map_flags[38:35], zero[39]
    output logic [2:0]  m_axis_tuser    // source[2:0]
);

    t_state      r_state, n_state;
    logic [15:0] r_clr_addr, n_clr_addr;
    logic [3:0]  r_flags, n_flags;

    // Item registers
    t_op         r_op;
    logic [15:0] r_addr;
    logic [7:0]  r_wd, r_dd;
    t_decode     r_dec;
    t_decode     dec;

    // Output register
    logic        r_m_valid, n_m_valid;
    logic [39:0] r_m_tdata, n_m_tdata;
    logic [2:0]  r_m_tuser, n_m_tuser;

    // Stores
    logic [7:0]  r_ram [65536];
    logic [7:0]  r_rom [ROM_DEPTH];
    logic [7:0]  r_ram_q, r_rom_q;

    logic        accept, out_free, go;
    logic        ram_we, rom_we;
    logic [15:0] ram_waddr;
    logic [7:0]  ram_wdata;

    // Result fields
    logic [7:0]  rd;
    t_src        src;
    t_dsel       dsel;
    logic        dwr;
    logic [15:0] daddr;
    logic [7:0]  dwd;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    // Decode of the incoming address under the current flags
    bmmd_decode #(
        .KERNAL_BASE (KERNAL_BASE),
        .BASIC_BASE  (BASIC_BASE),
        .CHAR_BASE   (CHAR_BASE),
        .DEV1_BASE   (DEV1_BASE),
        .DEV2_BASE   (DEV2_BASE)
    ) u_decode (
        .i_addr  (s_axis_tdata[15:0]),
        .i_flags (r_flags),
        .o_dec   (dec)
    );

    // State, flags, clear counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= 16'h0000;
            r_flags    <= 4'h0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_flags    <= n_flags;
            r_m_valid  <= n_m_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_op'(s_axis_tuser);
            r_addr <= s_axis_tdata[15:0];
            r_wd   <= s_axis_tdata[23:16];
            r_dd   <= s_axis_tdata[31:24];
            r_dec  <= dec;
        end
        r_m_tdata <= n_m_tdata;
        r_m_tuser <= n_m_tuser;
    end

    // Main RAM: read on accept, written in the execute cycle or by the clear pass.
    // Reads and writes never target the same item cycle, so no forwarding.
    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_ram[ram_waddr] <= ram_wdata;
        end
        if (accept) begin
            r_ram_q <= r_ram[s_axis_tdata[15:0]];
        end
    end

    // ROM images: read on accept, loaded in the execute cycle
    always_ff @(posedge i_clk) begin
        if (rom_we) begin
            r_rom[r_dec.rom_ld_idx] <= r_wd;
        end
        if (accept) begin
            r_rom_q <= r_rom[dec.rom_rd_idx];
        end
    end

    // Item execution: result fields and store write requests
    always_comb begin
        rd     = 8'h00;
        src    = SRC_RAM;
        dsel   = DSEL_NONE;
        dwr    = 1'b0;
        daddr  = 16'h0000;
        dwd    = 8'h00;
        ram_we = 1'b0;
        rom_we = 1'b0;
        go     = (r_state == ST_EXEC) && out_free;
        n_flags = r_flags;
        case (r_op)
            OP_READ: begin
                if (r_dec.hit_k) begin
                    rd  = r_rom_q;
                    src = SRC_KERNAL;
                end else if (r_dec.hit_c) begin
                    rd  = r_rom_q;
                    src = SRC_CHAR;
                end else if (r_dec.hit_b) begin
                    rd  = r_rom_q;
                    src = SRC_BASIC;
                end else if (r_dec.hit_d1 || r_dec.hit_d2) begin
                    rd    = r_dd;
                    src   = r_dec.hit_d1 ? SRC_DEV1 : SRC_DEV2;
                    dsel  = r_dec.hit_d1 ? DSEL_DEV1 : DSEL_DEV2;
                    daddr = r_addr;
                end else begin
                    rd = r_ram_q;
                end
            end
            OP_WRITE: begin
                if (r_dec.hit_k || r_dec.hit_b || r_dec.hit_c) begin
                    src = SRC_DROP;
                end else if (r_dec.hit_d1 || r_dec.hit_d2) begin
                    src   = r_dec.hit_d1 ? SRC_DEV1 : SRC_DEV2;
                    dsel  = r_dec.hit_d1 ? DSEL_DEV1 : DSEL_DEV2;
                    dwr   = 1'b1;
                    daddr = r_addr;
                    dwd   = r_wd;
                end else begin
                    ram_we = go;
                    if (go && (r_addr == BANK_REG_ADDR)) begin
                        n_flags = bank_flags(r_wd[2:0]);
                    end
                end
            end
            OP_LOAD: begin
                if (r_dec.in_k) begin
                    src = SRC_KERNAL;
                end else if (r_dec.in_c) begin
                    src = SRC_CHAR;
                end else if (r_dec.in_b) begin
                    src = SRC_BASIC;
                end else begin
                    src = SRC_DROP;
                end
                rom_we = go && (r_dec.in_k || r_dec.in_c || r_dec.in_b);
            end
            default: begin
                // unused operation code: no-op
            end
        endcase

        // Clear pass owns the RAM write port while it runs
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = 8'h00;
        end else begin
            ram_waddr = r_addr;
            ram_wdata = r_wd;
        end
    end

    // Sequencer and output register load
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_tdata  = r_m_tdata;
        n_m_tuser  = r_m_tuser;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 16'h0001;
                if (r_clr_addr == 16'hFFFF) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (go) begin
                    n_state   = ST_IDLE;
                    n_m_valid = 1'b1;
                    n_m_tdata = {1'b0, n_flags, dwd, daddr, dwr, dsel, rd};
                    n_m_tuser = src;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A stalled item stays in execute until the output register frees
    a_exec_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && !out_free) |=> (r_state == ST_EXEC))
        else $error("item left execute while output was blocked");

    // A new result appears only out of the execute cycle
    a_load_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !$past(r_m_valid)) |-> $past(r_state == ST_EXEC))
        else $error("output loaded outside execute");

    // Char and I/O are never mapped together; no ROM bit means all clear
    a_flags_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_flags[FLAG_CHAR] && r_flags[FLAG_IO]) &&
        ((r_flags[FLAG_KERNAL] || r_flags[FLAG_BASIC]) || (r_flags == 4'h0)))
        else $error("illegal map flag combination");

    // RAM and ROM are never written in the same cycle
    a_one_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && rom_we))
        else $error("RAM and ROM written together");

    // A device select only goes with a device source
    a_dev_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_m_tdata[9:8] != DSEL_NONE)) |->
        (r_m_tuser == SRC_DEV1 || r_m_tuser == SRC_DEV2))
        else $error("device select without device source");

endmodule

### sv/bmmd_decode.sv
// Address decoder: region membership, mapped hits and ROM store indexes.
// Depends on bmmd_pkg.
module bmmd_decode
    import bmmd_pkg::*;
#(
    parameter logic [15:0] KERNAL_BASE = BMMD_KERNAL_BASE,
    parameter logic [15:0] BASIC_BASE  = BMMD_BASIC_BASE,
    parameter logic [15:0] CHAR_BASE   = BMMD_CHAR_BASE,
    parameter logic [15:0] DEV1_BASE   = BMMD_DEV1_BASE,
    parameter logic [15:0] DEV2_BASE   = BMMD_DEV2_BASE
) (
    input  logic [15:0] i_addr,
    input  logic [3:0]  i_flags,
    output t_decode     o_dec
);

    logic [16:0] off_k, off_b, off_c, off_d1, off_d2;
    logic        in_d1, in_d2;

    // Offsets; bit 16 is the borrow when the address is below the base
    assign off_k  = {1'b0, i_addr} - {1'b0, KERNAL_BASE};
    assign off_b  = {1'b0, i_addr} - {1'b0, BASIC_BASE};
    assign off_c  = {1'b0, i_addr} - {1'b0, CHAR_BASE};
    assign off_d1 = {1'b0, i_addr} - {1'b0, DEV1_BASE};
    assign off_d2 = {1'b0, i_addr} - {1'b0, DEV2_BASE};

    assign in_d1 = !off_d1[16] && (off_d1[15:0] < 16'(DEV_SIZE));
    assign in_d2 = !off_d2[16] && (off_d2[15:0] < 16'(DEV_SIZE));

    always_comb begin
        o_dec.in_k   = !off_k[16] && (off_k[15:0] < 16'(KERNAL_SIZE));
        o_dec.in_c   = !off_c[16] && (off_c[15:0] < 16'(CHAR_SIZE));
        o_dec.in_b   = !off_b[16] && (off_b[15:0] < 16'(BASIC_SIZE));
        o_dec.hit_k  = i_flags[FLAG_KERNAL] && o_dec.in_k;
        o_dec.hit_c  = i_flags[FLAG_CHAR] && o_dec.in_c;
        o_dec.hit_b  = i_flags[FLAG_BASIC] && o_dec.in_b;
        o_dec.hit_d1 = i_flags[FLAG_IO] && in_d1;
        o_dec.hit_d2 = i_flags[FLAG_IO] && in_d2;

        // Read index follows mapped priority: kernal, char, basic
        if (o_dec.hit_k) begin
            o_dec.rom_rd_idx = ROM_KERNAL_OFS + ROM_AW'(off_k[12:0]);
        end else if (o_dec.hit_c) begin
            o_dec.rom_rd_idx = ROM_CHAR_OFS + ROM_AW'(off_c[11:0]);
        end else begin
            o_dec.rom_rd_idx = ROM_BASIC_OFS + ROM_AW'(off_b[12:0]);
        end

        // Load index follows range priority regardless of mapping
        if (o_dec.in_k) begin
            o_dec.rom_ld_idx = ROM_KERNAL_OFS + ROM_AW'(off_k[12:0]);
        end else if (o_dec.in_c) begin
            o_dec.rom_ld_idx = ROM_CHAR_OFS + ROM_AW'(off_c[11:0]);
        end else begin
            o_dec.rom_ld_idx = ROM_BASIC_OFS + ROM_AW'(off_b[12:0]);
        end
    end

endmodule

### tb/banked_memory_map_decoder_core_tb.sv
// Self-checking testbench for banked_memory_map_decoder_core: a directed table, then
// random bus accesses, checked against a behavioral model of RAM, ROM images and map flags.
// Depends on bmmd_pkg and the core RTL.
module banked_memory_map_decoder_core_tb
    import bmmd_pkg::*;
();

    // Unused operation code: the core must answer with a no-op result
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned DIRECTED_ROWS = 25;
    localparam int unsigned RANDOM_ITEMS = 450;
    localparam int unsigned STEADY_FROM = 390;

    // Region boundaries and other interesting addresses
    localparam logic [15:0] EDGE_ADDRS [18] = '{
        16'h0000, 16'h0001, 16'h0002, 16'h9FFF, 16'hA000, 16'hBFFF,
        16'hC000, 16'hCFFF, 16'hD000, 16'hDBFF, 16'hDC00, 16'hDCFF,
        16'hDD00, 16'hDDFF, 16'hDE00, 16'hDFFF, 16'hE000, 16'hFFFF
    };

    typedef struct packed {
        logic [7:0]  rd;
        t_src        src;
        t_dsel       dsel;
        logic        dwr;
        logic [15:0] daddr;
        logic [7:0]  dwd;
        logic [3:0]  flags;
    } t_access_result;

    typedef struct packed {
        logic [1:0]     op;
        logic [15:0]    addr;
        logic [7:0]     wd;
        logic [7:0]     dd;
        logic           typed;
        t_access_result want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    // Behavioral copy of the memory map
    logic [7:0]  ram_mem [0:65535];
    logic [7:0]  kernal_img [0:KERNAL_SIZE-1];
    logic [7:0]  basic_img [0:BASIC_SIZE-1];
    logic [7:0]  char_img [0:CHAR_SIZE-1];
    bit          kernal_set [0:KERNAL_SIZE-1];
    bit          basic_set [0:BASIC_SIZE-1];
    bit          char_set [0:CHAR_SIZE-1];
    logic [3:0]  map_flags = 4'h0;
    logic [15:0] loaded_addrs [$];

    t_access_result pending_q [$];
    t_stim_row      dir_tab [DIRECTED_ROWS];
    int unsigned    mismatches = 0;
    int unsigned    checked = 0;
    int unsigned    map_changes = 0;
    int unsigned    op_count [4];
    logic           steady_mode = 1'b0;
    int unsigned    hold_left = 0;

    banked_memory_map_decoder_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),        // address[15:0], write_data[23:16],
                                        // device_read_data[31:24]
        .s_axis_tuser  (s_user),        // operation[1:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),  // read_data, device_select, device_write,
                                        // device_address, device_write_data, map_flags
        .m_axis_tuser  (m_axis_tuser)   // source[2:0]
    );

    always #5 i_clk = ~i_clk;

    function automatic bit in_window(input logic [15:0] a, input logic [15:0] base,
                                     input int unsigned size);
        return (a >= base) && ((a - base) < size);
    endfunction

    // True when a read of this address would hit a mapped ROM entry never loaded
    function automatic bit rom_gap(input logic [15:0] a);
        if (map_flags[FLAG_KERNAL] && in_window(a, BMMD_KERNAL_BASE, KERNAL_SIZE))
            return !kernal_set[13'(a - BMMD_KERNAL_BASE)];
        if (map_flags[FLAG_CHAR] && in_window(a, BMMD_CHAR_BASE, CHAR_SIZE))
            return !char_set[12'(a - BMMD_CHAR_BASE)];
        if (map_flags[FLAG_BASIC] && in_window(a, BMMD_BASIC_BASE, BASIC_SIZE))
            return !basic_set[13'(a - BMMD_BASIC_BASE)];
        return 1'b0;
    endfunction

    // Address mix weighted toward region interiors, edges and loaded ROM bytes
    function automatic logic [15:0] pick_address();
        case ($urandom_range(0, 8))
            0: return 16'($urandom_range(0, 63));
            1: return BMMD_BASIC_BASE + 16'($urandom_range(0, BASIC_SIZE - 1));
            2: return BMMD_CHAR_BASE + 16'($urandom_range(0, CHAR_SIZE - 1));
            3: return BMMD_DEV1_BASE + 16'($urandom_range(0, 2 * DEV_SIZE - 1));
            4: return BMMD_KERNAL_BASE + 16'($urandom_range(0, KERNAL_SIZE - 1));
            5: return 16'($urandom);
            6: return EDGE_ADDRS[$urandom_range(0, 17)];
            default: begin
                if (loaded_addrs.size() == 0)
                    return 16'($urandom_range(0, 63));
                return loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
            end
        endcase
    endfunction

    // Expected result of one access; updates the model state
    task automatic decode_access(input logic [1:0] op, input logic [15:0] addr,
                                 input logic [7:0] wd, input logic [7:0] dd,
                                 output t_access_result r);
        logic in_k, in_c, in_b, hit_k, hit_c, hit_b, hit_d1, hit_d2;
        logic [12:0] ko, bo;
        logic [11:0] co;
        logic [2:0]  v;
        logic [3:0]  old_flags;
        in_k   = in_window(addr, BMMD_KERNAL_BASE, KERNAL_SIZE);
        in_c   = in_window(addr, BMMD_CHAR_BASE, CHAR_SIZE);
        in_b   = in_window(addr, BMMD_BASIC_BASE, BASIC_SIZE);
        hit_k  = map_flags[FLAG_KERNAL] && in_k;
        hit_c  = map_flags[FLAG_CHAR] && in_c;
        hit_b  = map_flags[FLAG_BASIC] && in_b;
        hit_d1 = map_flags[FLAG_IO] && in_window(addr, BMMD_DEV1_BASE, DEV_SIZE);
        hit_d2 = map_flags[FLAG_IO] && in_window(addr, BMMD_DEV2_BASE, DEV_SIZE);
        ko = 13'(addr - BMMD_KERNAL_BASE);
        bo = 13'(addr - BMMD_BASIC_BASE);
        co = 12'(addr - BMMD_CHAR_BASE);
        old_flags = map_flags;
        r = '0;
        case (op)
            OP_READ: begin
                if (hit_k) begin
                    r.rd = kernal_img[ko];
                    r.src = SRC_KERNAL;
                end else if (hit_c) begin
                    r.rd = char_img[co];
                    r.src = SRC_CHAR;
                end else if (hit_b) begin
                    r.rd = basic_img[bo];
                    r.src = SRC_BASIC;
                end else if (hit_d1 || hit_d2) begin
                    r.rd = dd;
                    r.src = hit_d1 ? SRC_DEV1 : SRC_DEV2;
                    r.dsel = hit_d1 ? DSEL_DEV1 : DSEL_DEV2;
                    r.daddr = addr;
                end else begin
                    r.rd = ram_mem[addr];
                    r.src = SRC_RAM;
                end
            end
            OP_WRITE: begin
                if (hit_k || hit_b || hit_c) begin
                    r.src = SRC_DROP;
                end else if (hit_d1 || hit_d2) begin
                    r.src = hit_d1 ? SRC_DEV1 : SRC_DEV2;
                    r.dsel = hit_d1 ? DSEL_DEV1 : DSEL_DEV2;
                    r.dwr = 1'b1;
                    r.daddr = addr;
                    r.dwd = wd;
                end else begin
                    ram_mem[addr] = wd;
                    r.src = SRC_RAM;
                    // Bank register: both ROM-select bits clear means all RAM
                    if (addr == BMMD_BANK_REG_ADDR) begin
                        v = wd[2:0];
                        map_flags = (v[1:0] == 2'b00) ? 4'h0 : {~v[2], v[2], v[1], v[0]};
                    end
                end
            end
            OP_LOAD: begin
                if (in_k) begin
                    kernal_img[ko] = wd;
                    kernal_set[ko] = 1'b1;
                    r.src = SRC_KERNAL;
                end else if (in_c) begin
                    char_img[co] = wd;
                    char_set[co] = 1'b1;
                    r.src = SRC_CHAR;
                end else if (in_b) begin
                    basic_img[bo] = wd;
                    basic_set[bo] = 1'b1;
                    r.src = SRC_BASIC;
                end else begin
                    r.src = SRC_DROP;
                end
                if (r.src != SRC_DROP && loaded_addrs.size() < 256)
                    loaded_addrs.push_back(addr);
            end
            default: ;
        endcase
        if (map_flags != old_flags)
            map_changes++;
        r.flags = map_flags;
    endtask

    // Drive one access, wait for its transfer, then queue what it should return
    task automatic send_access(input logic [1:0] op, input logic [15:0] addr,
                               input logic [7:0] wd, input logic [7:0] dd,
                               input logic typed, input t_access_result want);
        t_access_result predicted;
        s_valid <= 1'b1;
        s_data  <= {dd, wd, addr};
        s_user  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_access(op, addr, wd, dd, predicted);
        pending_q.push_back(typed ? want : predicted);
        op_count[op]++;
    endtask

    // Occasional sender gaps, none in steady mode
    task automatic maybe_gap();
        if (!steady_mode && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // Receiver stalls in random bursts
    always @(posedge i_clk) begin
        if (!steady_mode && hold_left == 0 && $urandom_range(0, 7) == 0)
            hold_left = $urandom_range(1, 5);
        if (!steady_mode && hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result checker: compare each output transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_access_result want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_ready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result transfer: tdata %h tuser %h",
                       m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                want = pending_q.pop_front();
                checked++;
                if (m_axis_tdata[7:0] !== want.rd) begin
                    $error("read_data: expected %0h, got %0h", want.rd, m_axis_tdata[7:0]);
                    mismatches++;
                end
                if (m_axis_tuser !== want.src) begin
                    $error("source: expected %0d, got %0d", want.src, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[9:8] !== want.dsel) begin
                    $error("device_select: expected %0d, got %0d", want.dsel,
                           m_axis_tdata[9:8]);
                    mismatches++;
                end
                if (m_axis_tdata[10] !== want.dwr) begin
                    $error("device_write: expected %0b, got %0b", want.dwr, m_axis_tdata[10]);
                    mismatches++;
                end
                if (m_axis_tdata[26:11] !== want.daddr) begin
                    $error("device_address: expected %0h, got %0h", want.daddr,
                           m_axis_tdata[26:11]);
                    mismatches++;
                end
                if (m_axis_tdata[34:27] !== want.dwd) begin
                    $error("device_write_data: expected %0h, got %0h", want.dwd,
                           m_axis_tdata[34:27]);
                    mismatches++;
                end
                if (m_axis_tdata[38:35] !== want.flags) begin
                    $error("map_flags: expected %0h, got %0h", want.flags,
                           m_axis_tdata[38:35]);
                    mismatches++;
                end
            end
        end
    end

    // Run limit, well past the RAM clearing pass and the slowest legal run
    initial begin
        #4000000;
        $display("banked_memory_map_decoder_core_tb failed");
        $finish;
    end

    // Stimulus
    initial begin
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  wd, dd;
        int unsigned pick;
        t_access_result none;
        none = '0;
        for (int i = 0; i < 65536; i++) ram_mem[i] = 8'h00;
        for (int i = 0; i < 4; i++) op_count[i] = 0;

        // Directed table; typed rows carry their own expectation
        dir_tab[0]  = '{OP_READ,   16'h0000, 8'h00, 8'h00, 1'b1,
                        '{8'h00, SRC_RAM, DSEL_NONE, 1'b0, 16'h0, 8'h00, 4'h0}};
        dir_tab[1]  = '{OP_READ,   16'hFFFF, 8'h00, 8'hFF, 1'b1,
                        '{8'h00, SRC_RAM, DSEL_NONE, 1'b0, 16'h0, 8'h00, 4'h0}};
        dir_tab[2]  = '{OP_LOAD,   16'hE000, 8'hA5, 8'h00, 1'b1,
                        '{8'h00, SRC_KERNAL, DSEL_NONE, 1'b0, 16'h0, 8'h00, 4'h0}};
        dir_tab[3]  = '{OP_LOAD,   16'hFFFF, 8'h5A, 8'h00, 1'b1,
                        '{8'h00, SRC_KERNAL, DSEL_NONE, 1'b0, 16'h0, 8'h00, 4'h0}};
        dir_tab[4]  = '{OP_LOAD,   16'hA000, 8'hFF, 8'h00, 1'b1,
                        '{8'h00, SRC_BASIC, DSEL_NONE, 1'b0, 16'h0, 8'h00, 4'h0}};
        dir_tab[5]  = '{OP_LOAD,   16'hBFFF, 8'h00, 8'h00, 1'b1,
                        '{8'h00, SRC_BASIC, DSEL_NONE, 1'b0, 16'h0, 8'h00, 4'h0}};
        dir_tab[6]  = '{OP_LOAD,   16'hD000, 8'h3C, 8'h00, 1'b1,
                        '{8'h00, SRC_CHAR, DSEL_NONE, 1'b0, 16'h0, 8'h00, 4'h0}};
        dir_tab[7]  = '{OP_LOAD,   16'hDFFF, 8'hC3, 8'h00, 1'b1,
                        '{8'h00, SRC_CHAR, DSEL_NONE, 1'b0, 16'h0, 8'h00, 4'h0}};
        // Loads outside every ROM range are refused
        dir_tab[8]  = '{OP_LOAD,   16'h0000, 8'h11, 8'h00, 1'b1,
                        '{8'h00, SRC_DROP, DSEL_NONE, 1'b0, 16'h0, 8'h00, 4'h0}};
        dir_tab[9]  = '{OP_LOAD,   16'hC000, 8'h22, 8'h00, 1'b1,
                        '{8'h00, SRC_DROP, DSEL_NONE, 1'b0, 16'h0, 8'h00, 4'h0}};
        dir_tab[10] = '{OP_UNUSED, 16'h1234, 8'hFF, 8'hFF, 1'b1,
                        '{8'h00, SRC_RAM, DSEL_NONE, 1'b0, 16'h0, 8'h00, 4'h0}};
        // All-RAM map: ROM range writes land in RAM
        dir_tab[11] = '{OP_WRITE,  16'hE000, 8'h77, 8'h00, 1'b0, none};
        dir_tab[12] = '{OP_READ,   16'hE000, 8'h00, 8'h00, 1'b0, none};
        // Kernal, basic and I/O mapped
        dir_tab[13] = '{OP_WRITE,  16'h0001, 8'h07, 8'h00, 1'b0, none};
        dir_tab[14] = '{OP_READ,   16'hE000, 8'h00, 8'h00, 1'b0, none};
        dir_tab[15] = '{OP_READ,   16'hFFFF, 8'h00, 8'h00, 1'b0, none};
        dir_tab[16] = '{OP_READ,   16'hA000, 8'h00, 8'h00, 1'b0, none};
        dir_tab[17] = '{OP_READ,   16'hDC00, 8'h00, 8'h99, 1'b0, none};
        dir_tab[18] = '{OP_WRITE,  16'hDDFF, 8'hEE, 8'h00, 1'b0, none};
        dir_tab[19] = '{OP_WRITE,  16'hBFFF, 8'h12, 8'h00, 1'b0, none};
        // Character ROM instead of I/O
        dir_tab[20] = '{OP_WRITE,  16'h0001, 8'h03, 8'h00, 1'b0, none};
        dir_tab[21] = '{OP_READ,   16'hD000, 8'h00, 8'h00, 1'b0, none};
        dir_tab[22] = '{OP_READ,   16'hDFFF, 8'h00, 8'hFF, 1'b0, none};
        // ROM-select bits clear, upper bits ignored: back to all RAM
        dir_tab[23] = '{OP_WRITE,  16'h0001, 8'hF8, 8'h00, 1'b0, none};
        dir_tab[24] = '{OP_READ,   16'hA000, 8'h00, 8'h00, 1'b0, none};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            send_access(dir_tab[i].op, dir_tab[i].addr, dir_tab[i].wd, dir_tab[i].dd,
                        dir_tab[i].typed, dir_tab[i].want);
            maybe_gap();
        end
        wait_results_done();

        // Random accesses with occasional bank switches
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == STEADY_FROM)
                steady_mode <= 1'b1;
            pick = $urandom_range(0, 99);
            wd   = 8'($urandom);
            dd   = 8'($urandom);
            addr = pick_address();
            if (pick < 8) begin
                op   = OP_WRITE;
                addr = BMMD_BANK_REG_ADDR;
            end else if (pick < 11) begin
                op = OP_UNUSED;
            end else if (pick < 30) begin
                op = OP_LOAD;
            end else if (pick < 65) begin
                op = OP_READ;
            end else begin
                op = OP_WRITE;
            end
            // Never read a ROM byte that was not loaded; load it instead
            if (op == OP_READ && rom_gap(addr))
                op = OP_LOAD;
            send_access(op, addr, wd, dd, 1'b0, none);
            if (i % 150 == 149)
                wait_results_done();
            else
                maybe_gap();
        end

        wait_results_done();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d accesses: %0d reads, %0d writes, %0d ROM loads, %0d no-ops.",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("Checked %0d results across %0d map flag changes, %0d mismatches.",
                 checked, map_changes, mismatches);
        if (mismatches == 0)
            $display("banked_memory_map_decoder_core_tb passed");
        else
            $display("banked_memory_map_decoder_core_tb failed");
        $finish;
    end

endmodule

### banked_memory_map_decoder_core.f
sv/bmmd_pkg.sv
sv/bmmd_decode.sv
sv/banked_memory_map_decoder_core.sv
tb/banked_memory_map_decoder_core_tb.sv
